// File: hdl/hcl_pkg.sv
package hcl_pkg;

    // Contour interval in metres.
    localparam int unsigned LEVEL_STEP = 100;

    // Reciprocal of the interval, scaled by 2^LEVEL_SHIFT and rounded up. It is
    // exact for every magnitude below 2^16.
    localparam int unsigned LEVEL_SHIFT = 24;
    localparam int unsigned LEVEL_RECIP = ((1 << LEVEL_SHIFT) + LEVEL_STEP - 1) / LEVEL_STEP;
    localparam int unsigned PROD_W      = 16 + 18;

    // Quotient width: the largest magnitude is 32767 + 99, giving 328.
    localparam int unsigned Q_W = 9;

    localparam logic signed [15:0] LEVEL_MAX = 16'sd32767;

    localparam logic [11:0] ROW_WIDTH_RESET = 12'd1201;

    // Register index codes of the configuration port.
    localparam logic REG_ROW_WIDTH = 1'b0;

    typedef logic signed [15:0] level_t;

    // Control that travels with a pixel down the pipeline.
    typedef struct packed {
        logic valid;
        logic drawn;
        logic row_end;
    } pix_ctl_t;

    // Tint for a non-negative level of q intervals: the largest w with
    // w^5 <= 13^5 * (100 q)^2, limited to 255. From 18 intervals upwards it is 255.
    function automatic logic [7:0] tint_of(input logic [Q_W-1:0] q);
        logic [7:0] w;
        begin
            case (q)
                9'd0:    w = 8'd0;
                9'd1:    w = 8'd82;
                9'd2:    w = 8'd108;
                9'd3:    w = 8'd127;
                9'd4:    w = 8'd142;
                9'd5:    w = 8'd156;
                9'd6:    w = 8'd167;
                9'd7:    w = 8'd178;
                9'd8:    w = 8'd188;
                9'd9:    w = 8'd197;
                9'd10:   w = 8'd206;
                9'd11:   w = 8'd214;
                9'd12:   w = 8'd221;
                9'd13:   w = 8'd228;
                9'd14:   w = 8'd235;
                9'd15:   w = 8'd242;
                9'd16:   w = 8'd248;
                9'd17:   w = 8'd254;
                default: w = 8'd255;
            endcase
            return w;
        end
    endfunction

endpackage

// File: hdl/hcl_line_store.sv
module hcl_line_store #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output hcl_pkg::level_t        rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  hcl_pkg::level_t        wr_data
);
    import hcl_pkg::*;

    level_t mem [DEPTH];
    level_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A write to the entry being read in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/hcl_level.sv
module hcl_level (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load1,
    input  logic signed [15:0]          height,
    input  logic                        load2,
    output hcl_pkg::level_t             level,
    output hcl_pkg::level_t             here,
    output logic [7:0]                  tint
);
    import hcl_pkg::*;

    logic signed [16:0]  biased;
    logic                neg;
    logic [15:0]         mag;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      q_reg;
    logic                neg_reg;
    logic [15:0]         scaled;
    level_t              level_next;
    level_t              here_reg;
    logic [7:0]          tint_reg;

    // Stage 1: bias by one interval less one so truncation rounds non-negative
    // heights up, then divide the magnitude by the interval through the reciprocal.
    always_comb
    begin
        biased = 17'(height) + 17'(LEVEL_STEP - 1);
        neg    = biased[16];
        mag    = neg ? 16'(-biased) : 16'(biased);
        prod   = PROD_W'(mag) * PROD_W'(LEVEL_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            q_reg   <= prod[LEVEL_SHIFT +: Q_W];
            neg_reg <= neg;
        end
    end

    // Stage 2: scale back up and limit to the signed range.
    always_comb
    begin
        scaled = 16'(q_reg) * 16'(LEVEL_STEP);
        if (neg_reg)
        begin
            level_next = -$signed(scaled);
        end
        else if (scaled > 16'(LEVEL_MAX))
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = $signed(scaled);
        end
    end

    // here_reg doubles as the left neighbour level, so it is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            here_reg <= '0;
        end
        else if (load2)
        begin
            here_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            tint_reg <= tint_of(q_reg);
        end
    end

    assign level = level_next;
    assign here  = here_reg;
    assign tint  = tint_reg;

endmodule

// File: hdl/height_contour_line_renderer.sv
// Contour-line renderer for a raster stream of elevation samples.
// The sample channel (sample_valid, sample_stall, height, frame_start) takes one
// signed elevation per item in raster order; frame_start marks the first sample
// of an image. The pixel channel (pixel_valid, pixel_stall, red, green, blue,
// drawn, row_end) returns one pixel item per sample, in order. An item moves on
// a channel at a rising edge where its valid is high and its stall is low.
// The row length is set through the APB port, register row_width at byte
// address 0; it is clamped into 3 to MAX_WIDTH and may only change while idle.
// From sample acceptance to pixel valid an item passes a stage that rounds the
// height and reads the line store, a stage that scales the level, looks up its
// tint and writes the line store, and the pixel output register. Throughput is
// one item per cycle unless the receiver stalls, set by the single line-store
// read and write each item needs. When the receiver stalls with a pixel
// waiting, the whole pipeline holds and sample_stall rises in the same cycle.
// Reset clears the pipeline, the column counter and the left level, marks the
// next row as the first, and loads row_width with 1201. The line store is not
// cleared; the first row of every image is never drawn, so it is always
// written before it is read.
module height_contour_line_renderer #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [15:0]  height,
    input  logic                frame_start,

    output logic                pixel_valid,
    input  logic                pixel_stall,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic                drawn,
    output logic                row_end
);
    import hcl_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned CMP_W = ((COL_W > 12) ? COL_W : 12) + 1;

    // Configuration port. Only bit 2 of the address selects a register; the
    // byte offset within a word is ignored.
    logic        reg_idx;
    logic        cfg_write;
    logic [11:0] row_width_reg;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_write && (reg_idx == REG_ROW_WIDTH))
        begin
            row_width_reg <= pwdata[11:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_WIDTH: prdata = {20'd0, row_width_reg};
            default:       prdata = '0;
        endcase
    end

    // Pipeline advance: everything moves whenever the output register is free.
    logic     advance;
    logic     accept;
    pix_ctl_t p1_reg;
    pix_ctl_t p2_reg;
    pix_ctl_t out_reg;

    assign advance      = !out_reg.valid || !pixel_stall;
    assign accept       = sample_valid && advance;
    assign sample_stall = !advance;

    // Raster position. The effective width is the register clamped into range.
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] last_col;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] col_cur;
    logic             first_row_reg;
    logic             first_row_next;
    logic             first_cur;
    logic             at_end;
    logic             draw_cur;

    always_comb
    begin
        width_ext = CMP_W'(row_width_reg);
        if (width_ext < CMP_W'(3))
        begin
            width_eff = CMP_W'(3);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        last_col = width_eff - CMP_W'(1);

        // A new image restarts the column count and the first-row marking.
        col_cur   = frame_start ? '0 : col_reg;
        first_cur = frame_start || first_row_reg;
        at_end    = (CMP_W'(col_cur) >= last_col);
        draw_cur  = !first_cur && (col_cur != '0) && !at_end;

        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (at_end)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next       = col_cur + COL_W'(1);
                first_row_next = first_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
        end
    end

    // Stage one holds the column so that stage two can write the level back.
    logic [COL_W-1:0] p1_col_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_col_reg <= col_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= '0;
            p2_reg  <= '0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            p1_reg  <= '{valid: sample_valid, drawn: draw_cur, row_end: at_end};
            p2_reg  <= p1_reg;
            out_reg <= p2_reg;
        end
    end

    // Level arithmetic and the line store, read at acceptance and written as the
    // item enters stage two.
    level_t     level;
    level_t     here;
    level_t     top_rd;
    level_t     top_reg;
    level_t     left_reg;
    logic [7:0] tint;
    logic       wr_en;

    assign wr_en = advance && p1_reg.valid;

    hcl_level u_level (
        .clk    (clk),
        .rst_n  (rst_n),
        .load1  (accept),
        .height (height),
        .load2  (wr_en),
        .level  (level),
        .here   (here),
        .tint   (tint)
    );

    hcl_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (top_rd),
        .wr_en   (wr_en),
        .wr_addr (p1_col_reg),
        .wr_data (level)
    );

    // The left neighbour is the level of the previous item, still held in the
    // level unit when the next item moves into stage two.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            top_reg  <= top_rd;
            left_reg <= here;
        end
    end

    // Colour rule, registered into the output stage.
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic       on_contour;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_comb
    begin
        on_contour = (here > 0) && (left_reg > 0) && (top_reg > 0)
                     && ((here != left_reg) || (here != top_reg));
        red_next   = 8'd0;
        green_next = 8'd0;
        blue_next  = 8'd0;
        if (p2_reg.drawn && !on_contour)
        begin
            if (here >= 0)
            begin
                red_next   = tint;
                green_next = 8'd255;
                blue_next  = tint;
            end
            else
            begin
                red_next   = 8'd255;
                green_next = 8'd255;
                blue_next  = 8'd255;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p2_reg.valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pixel_valid = out_reg.valid;
    assign drawn       = out_reg.drawn;
    assign row_end     = out_reg.row_end;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    // A border pixel at the end of a row is never drawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> !(drawn && row_end))
        else $error("row end pixel marked as drawn");

    // Undrawn pixels carry no colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !drawn) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("border pixel with colour");

    // An accepted item always occupies stage one in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> p1_reg.valid)
        else $error("accepted item lost before stage one");

    // The column wraps to zero after a row end and marks later rows as drawable.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_end) |=> (col_reg == '0 && !first_row_reg))
        else $error("column did not wrap at row end");

endmodule
